// ===== sv/lfpd_pkg.sv =====
package lfpd_pkg;

  localparam int RUN_COUNTER_BITS = 16;
  localparam int RUN_W = RUN_COUNTER_BITS;
  localparam int DIVISOR_W = RUN_W + 1;

  localparam int SAMPLE_W = 10;
  localparam int GAIN_W = 10;
  localparam int SPEED_W = 8;
  localparam int DRIVE_W = 9;
  localparam int CORR_W = 14;
  localparam int ERR_W = 3;

  // |gain_derivative * (error - error_before_change)| <= 1023*4
  localparam int NUM_MAG_W = 12;
  localparam int DIV_STEPS = NUM_MAG_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 10;

  localparam logic signed [DRIVE_W:0] DRIVE_LIMIT = 255;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED = 3;

  localparam logic signed [ERR_W-1:0] ERR_CENTRE = 0;
  localparam logic signed [ERR_W-1:0] ERR_LEFT = -1;
  localparam logic signed [ERR_W-1:0] ERR_RIGHT = 1;
  localparam logic signed [ERR_W-1:0] ERR_LOST_RIGHT = 2;
  localparam logic signed [ERR_W-1:0] ERR_LOST_LEFT = -2;

  typedef struct packed {
    logic load;      // take the sample pair, update run state
    logic mul;       // form P term and derivative numerator
    logic div_step;  // one restoring division step
    logic finish;    // build result into output register
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

// ===== sv/lfpd_ctrl.sv =====
module lfpd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lfpd_pkg::cmd_t cmd,
  input  lfpd_pkg::sts_t sts
);
  import lfpd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && (state == S_IDLE);
    cmd.mul = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.finish = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_MUL;
        S_MUL:  state <= S_DIV;
        S_DIV:  if (sts.div_last) state <= S_FIN;
        S_FIN: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/lfpd_dpath.sv =====
module lfpd_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  lfpd_pkg::cmd_t                     cmd,
  output lfpd_pkg::sts_t                     sts,
  input  logic [lfpd_pkg::SAMPLE_W-1:0]      left_sample,
  input  logic [lfpd_pkg::SAMPLE_W-1:0]      right_sample,
  input  logic [lfpd_pkg::SAMPLE_W-1:0]      sensor_threshold,
  input  logic [lfpd_pkg::GAIN_W-1:0]        gain_proportional,
  input  logic [lfpd_pkg::GAIN_W-1:0]        gain_derivative,
  input  logic [lfpd_pkg::SPEED_W-1:0]       base_speed,
  output logic signed [lfpd_pkg::DRIVE_W-1:0] left_drive,
  output logic signed [lfpd_pkg::DRIVE_W-1:0] right_drive,
  output logic signed [lfpd_pkg::CORR_W-1:0]  correction,
  output logic signed [lfpd_pkg::ERR_W-1:0]   position_error,
  output logic                               drive_clipped
);
  import lfpd_pkg::*;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;
  localparam logic [RUN_W-1:0] RUN_ONE = RUN_W'(1);

  // run state
  logic signed [ERR_W-1:0] last_err;
  logic signed [ERR_W-1:0] ebc;
  logic [RUN_W-1:0]        prev_run;
  logic [RUN_W-1:0]        cur_run;

  // per-item working registers
  logic signed [ERR_W-1:0]  err_q;
  logic signed [ERR_W:0]    diff_q;
  logic [DIVISOR_W-1:0]     divisor;
  logic signed [CORR_W-1:0] prop;
  logic                     num_neg;
  logic [NUM_MAG_W-1:0]     quo;
  logic [DIVISOR_W-1:0]     rem;
  logic [DIV_CNT_W-1:0]     div_cnt;

  logic signed [ERR_W-1:0] err_new;
  logic signed [ERR_W-1:0] ebc_next;
  logic [RUN_W-1:0]        prev_run_next;
  logic [RUN_W-1:0]        cur_run_next;
  logic                    on_l, on_r, changed;

  always_comb begin
    on_l = left_sample > sensor_threshold;
    on_r = right_sample > sensor_threshold;
    priority if (on_l && on_r) err_new = ERR_CENTRE;
    else if (on_l) err_new = ERR_LEFT;
    else if (on_r) err_new = ERR_RIGHT;
    else if (last_err > ERR_CENTRE) err_new = ERR_LOST_RIGHT;
    else err_new = ERR_LOST_LEFT;
    changed = (err_new != last_err);
    ebc_next = changed ? last_err : ebc;
    prev_run_next = changed ? cur_run : prev_run;
    cur_run_next = changed ? RUN_ONE : cur_run;
  end

  // multiplier operands, all fit in CORR_W signed bits
  logic signed [CORR_W-1:0] gp_s, gd_s, err_x, diff_x, prop_mul, num_mul;
  logic [CORR_W-1:0]        num_abs;

  always_comb begin
    gp_s = signed'({{(CORR_W-GAIN_W){1'b0}}, gain_proportional});
    gd_s = signed'({{(CORR_W-GAIN_W){1'b0}}, gain_derivative});
    err_x = CORR_W'(err_q);
    diff_x = CORR_W'(diff_q);
    prop_mul = gp_s * err_x;
    num_mul = gd_s * diff_x;
    num_abs = num_mul[CORR_W-1] ? CORR_W'(-num_mul) : CORR_W'(num_mul);
  end

  // restoring division step
  logic [DIVISOR_W:0]   trial;
  logic                 ge;
  logic [DIVISOR_W:0]   trial_sub;

  always_comb begin
    trial = {rem, quo[NUM_MAG_W-1]};
    ge = trial >= {1'b0, divisor};
    trial_sub = trial - {1'b0, divisor};
  end

  assign sts.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  // result assembly
  logic signed [CORR_W-1:0]  deriv;
  logic signed [CORR_W-1:0]  corr;
  logic signed [CORR_W:0]    speed_x, l_raw, r_raw;
  logic signed [DRIVE_W-1:0] l_sat, r_sat;
  logic                      l_clip, r_clip;

  always_comb begin
    if (divisor == '0) deriv = '0;
    else if (num_neg) deriv = -signed'(CORR_W'(quo));
    else deriv = signed'(CORR_W'(quo));
    corr = prop + deriv;
    speed_x = signed'({{(CORR_W+1-SPEED_W){1'b0}}, base_speed});
    l_raw = (CORR_W+1)'(corr) - speed_x;
    r_raw = (CORR_W+1)'(corr) + speed_x;
    l_clip = 1'b1;
    r_clip = 1'b1;
    if (l_raw > (CORR_W+1)'(DRIVE_LIMIT)) l_sat = DRIVE_W'(DRIVE_LIMIT);
    else if (l_raw < -(CORR_W+1)'(DRIVE_LIMIT)) l_sat = DRIVE_W'(-DRIVE_LIMIT);
    else begin
      l_sat = DRIVE_W'(l_raw);
      l_clip = 1'b0;
    end
    if (r_raw > (CORR_W+1)'(DRIVE_LIMIT)) r_sat = DRIVE_W'(DRIVE_LIMIT);
    else if (r_raw < -(CORR_W+1)'(DRIVE_LIMIT)) r_sat = DRIVE_W'(-DRIVE_LIMIT);
    else begin
      r_sat = DRIVE_W'(r_raw);
      r_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= '0;
      ebc <= '0;
      prev_run <= '0;
      cur_run <= '0;
      div_cnt <= '0;
    end else begin
      if (cmd.load) begin
        last_err <= err_new;
        ebc <= ebc_next;
        prev_run <= prev_run_next;
        cur_run <= (cur_run_next != RUN_MAX) ? cur_run_next + RUN_ONE : cur_run_next;
      end
      if (cmd.mul) div_cnt <= '0;
      else if (cmd.div_step) div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_q <= err_new;
      diff_q <= (ERR_W+1)'(err_new) - (ERR_W+1)'(ebc_next);
      divisor <= {1'b0, prev_run_next} + {1'b0, cur_run_next};
    end
    if (cmd.mul) begin
      prop <= prop_mul;
      num_neg <= num_mul[CORR_W-1];
      quo <= num_abs[NUM_MAG_W-1:0];
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[NUM_MAG_W-2:0], ge};
    end
    if (cmd.finish) begin
      left_drive <= l_sat;
      right_drive <= r_sat;
      correction <= corr;
      position_error <= err_q;
      drive_clipped <= l_clip || r_clip;
    end
  end

endmodule

// ===== sv/line_follow_pd_steering_top.sv =====
// Two-sensor line follower with PD steering. Each transaction on s_axis carries a
// left/right reflectance sample pair; one result per pair appears on m_axis with
// both wheel drives (saturated to +/-255, drive_clipped set when either was),
// the correction term and the position error. Items are handled one at a time:
// an accepted item first takes the pair and updates the run state, then forms
// both gain products, then runs the bit-serial divider that scales the
// derivative by the sum of the last two run lengths, then sums, saturates and
// loads the output register; the next pair can be accepted in the cycle after.
// A result waiting in the output register does not stop the next pair being
// accepted, but that pair's final step is held until the waiting result is
// taken. Registers on cfg_*: 0 threshold, 1 kp, 2 kd, 3 base speed; other
// indices are ignored. Write them only while the block is idle.
module line_follow_pd_steering_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [lfpd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // left_sample, right_sample
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // left_drive, right_drive, correction, position_error, drive_clipped
  output logic [lfpd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lfpd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import lfpd_pkg::*;

  logic [SAMPLE_W-1:0] sensor_threshold;
  logic [GAIN_W-1:0]   gain_proportional;
  logic [GAIN_W-1:0]   gain_derivative;
  logic [SPEED_W-1:0]  base_speed;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_threshold <= SAMPLE_W'(512);
      gain_proportional <= GAIN_W'(20);
      gain_derivative <= GAIN_W'(10);
      base_speed <= SPEED_W'(100);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD: sensor_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_GAIN_P:    gain_proportional <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    gain_derivative <= cfg_data[GAIN_W-1:0];
        REG_SPEED:     base_speed <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  sts_t sts;

  logic signed [DRIVE_W-1:0] left_drive, right_drive;
  logic signed [CORR_W-1:0]  correction;
  logic signed [ERR_W-1:0]   position_error;
  logic                      drive_clipped;

  lfpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lfpd_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .left_sample       (s_axis_tdata[SAMPLE_W-1:0]),
    .right_sample      (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .sensor_threshold  (sensor_threshold),
    .gain_proportional (gain_proportional),
    .gain_derivative   (gain_derivative),
    .base_speed        (base_speed),
    .left_drive        (left_drive),
    .right_drive       (right_drive),
    .correction        (correction),
    .position_error    (position_error),
    .drive_clipped     (drive_clipped)
  );

  assign m_axis_tdata = {
    {(OUT_TDATA_W - 2*DRIVE_W - CORR_W - ERR_W - 1){1'b0}},
    drive_clipped, position_error, correction, right_drive, left_drive
  };

endmodule

// ===== tb/line_follow_pd_steering_top_test.sv =====
module line_follow_pd_steering_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfpd_pkg::*;

  // indices outside the register map, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_FIRST = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_TOP = 8'hFF;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic                        drive_clipped;
    logic signed [ERR_W-1:0]     position_error;
    logic signed [CORR_W-1:0]    correction;
    logic signed [DRIVE_W-1:0]   right_drive;
    logic signed [DRIVE_W-1:0]   left_drive;
  } steer_t;

  typedef enum int {PAT_CENTRE, PAT_LEFT, PAT_RIGHT, PAT_LOST, PAT_NOISE} pattern_t;

  logic                     clk;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_TDATA_W-1:0]    s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  // shadow registers and steering state
  logic [SAMPLE_W-1:0]      cur_threshold;
  logic [GAIN_W-1:0]        cur_kp;
  logic [GAIN_W-1:0]        cur_kd;
  logic [SPEED_W-1:0]       cur_speed;
  logic signed [ERR_W-1:0]  line_err;
  logic signed [ERR_W-1:0]  err_at_change;
  logic [RUN_W-1:0]         prior_run;
  logic [RUN_W-1:0]         this_run;

  steer_t pending_steer[$];
  int idle_pct;
  int stall_pct;
  int fail_count;
  int pairs_sent;
  int results_checked;
  int reg_writes;

  line_follow_pd_steering_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("line_follow_pd_steering_top_test: FAIL");
    $finish;
  end

  function automatic steer_t predict_steering(input logic [SAMPLE_W-1:0] ls,
                                              input logic [SAMPLE_W-1:0] rs);
    steer_t r;
    logic signed [ERR_W-1:0] err;
    logic on_l;
    logic on_r;
    int divisor;
    int num;
    int deriv;
    int corr;
    int ldrv;
    int rdrv;
    on_l = ls > cur_threshold;
    on_r = rs > cur_threshold;
    if (on_l && on_r) err = ERR_CENTRE;
    else if (on_l) err = ERR_LEFT;
    else if (on_r) err = ERR_RIGHT;
    else err = (line_err > 0) ? ERR_LOST_RIGHT : ERR_LOST_LEFT;
    if (err != line_err) begin
      err_at_change = line_err;
      prior_run = this_run;
      this_run = RUN_W'(1);
    end
    divisor = int'(prior_run) + int'(this_run);
    num = int'(cur_kd) * (int'(err) - int'(err_at_change));
    // SV division truncates toward zero, as the block must
    deriv = (divisor == 0) ? 0 : num / divisor;
    corr = int'(cur_kp) * int'(err) + deriv;
    if (this_run != '1) this_run = this_run + 1'b1;
    ldrv = corr - int'(cur_speed);
    rdrv = corr + int'(cur_speed);
    r.drive_clipped = 1'b0;
    if (ldrv > int'(DRIVE_LIMIT)) begin
      ldrv = int'(DRIVE_LIMIT);
      r.drive_clipped = 1'b1;
    end else if (ldrv < -int'(DRIVE_LIMIT)) begin
      ldrv = -int'(DRIVE_LIMIT);
      r.drive_clipped = 1'b1;
    end
    if (rdrv > int'(DRIVE_LIMIT)) begin
      rdrv = int'(DRIVE_LIMIT);
      r.drive_clipped = 1'b1;
    end else if (rdrv < -int'(DRIVE_LIMIT)) begin
      rdrv = -int'(DRIVE_LIMIT);
      r.drive_clipped = 1'b1;
    end
    r.left_drive = ldrv[DRIVE_W-1:0];
    r.right_drive = rdrv[DRIVE_W-1:0];
    r.correction = corr[CORR_W-1:0];
    r.position_error = err;
    line_err = err;
    return r;
  endfunction

  function automatic int sample_above(input int thr);
    return (thr >= SAMPLE_MAX) ? SAMPLE_MAX : $urandom_range(SAMPLE_MAX, thr + 1);
  endfunction

  function automatic int sample_below(input int thr);
    return $urandom_range(thr, 0);
  endfunction

  // extremes now and then, small values often so that not every item clips
  function automatic int pick_reg_value(input int maxv);
    int sel;
    sel = $urandom_range(7);
    unique case (sel)
      0: return 0;
      1: return maxv;
      2, 3: return $urandom_range((maxv < 40) ? maxv : 40, 0);
      default: return $urandom_range(maxv, 0);
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    steer_t want;
    steer_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_steer.size() == 0) begin
        $error("steering result with no sensor pair outstanding");
        fail_count++;
      end else begin
        want = pending_steer.pop_front();
        got = steer_t'(m_axis_tdata[$bits(steer_t)-1:0]);
        check_field("left_drive", want.left_drive, got.left_drive);
        check_field("right_drive", want.right_drive, got.right_drive);
        check_field("correction", want.correction, got.correction);
        check_field("position_error", want.position_error, got.position_error);
        check_field("drive_clipped", want.drive_clipped, got.drive_clipped);
        results_checked++;
      end
    end
  end

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send_pair(input int ls, input int rs);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W - 2 * SAMPLE_W){1'b0}},
                     rs[SAMPLE_W-1:0], ls[SAMPLE_W-1:0]};
    do @(posedge clk); while (!s_axis_tready);
    pending_steer.push_back(predict_steering(ls[SAMPLE_W-1:0], rs[SAMPLE_W-1:0]));
    pairs_sent++;
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_steer.size() != 0) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    unique case (idx)
      REG_THRESHOLD: cur_threshold = val[SAMPLE_W-1:0];
      REG_GAIN_P:    cur_kp = val[GAIN_W-1:0];
      REG_GAIN_D:    cur_kd = val[GAIN_W-1:0];
      REG_SPEED:     cur_speed = val[SPEED_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic randomise_registers();
    logic [1:0] junk;
    junk = 2'($urandom_range(3));
    write_reg(REG_THRESHOLD, CFG_DATA_W'(pick_reg_value(SAMPLE_MAX)));
    write_reg(REG_GAIN_P, CFG_DATA_W'(pick_reg_value((1 << GAIN_W) - 1)));
    write_reg(REG_GAIN_D, CFG_DATA_W'(pick_reg_value((1 << GAIN_W) - 1)));
    // bits above the speed field ride along and must be dropped
    write_reg(REG_SPEED, {junk, SPEED_W'(pick_reg_value((1 << SPEED_W) - 1))});
  endtask

  // First pair after reset has no run yet, so the derivative divisor is zero.
  task automatic test_start_and_sensor_cases();
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MAX, 0);
    send_pair(SAMPLE_MAX, 0);
    send_pair(0, 0);
    send_pair(0, SAMPLE_MAX);
    send_pair(0, 0);
    send_pair(0, 0);
    // exactly at threshold is not over the line
    send_pair(512, 512);
    send_pair(513, 513);
    send_pair(513, 512);
    send_pair(512, 513);
  endtask

  task automatic test_register_extremes();
    drain_pipeline();
    write_reg(REG_THRESHOLD, '0);
    write_reg(REG_GAIN_P, '1);
    write_reg(REG_GAIN_D, '1);
    write_reg(REG_SPEED, '1);
    write_reg(REG_UNMAPPED_FIRST, '1);
    write_reg(REG_UNMAPPED_TOP, 10'h155);
    send_pair(0, 0);
    send_pair(0, 1);
    send_pair(0, 0);
    send_pair(1, 0);
    send_pair(1, 1);
    send_pair(1, 0);
    drain_pipeline();
    write_reg(REG_THRESHOLD, '1);
    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_D, '0);
    write_reg(REG_SPEED, '0);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MAX, 0);
    send_pair(0, SAMPLE_MAX);
  endtask

  // Runs of one line position with random samples, so the derivative sees
  // a spread of divisors; noise runs break the pattern.
  task automatic test_random_traffic(input int idle, input int stall);
    pattern_t pat;
    int run_len;
    int sent;
    int ls;
    int rs;
    idle_pct = idle;
    stall_pct = stall;
    for (int round = 0; round < 2; round++) begin
      drain_pipeline();
      randomise_registers();
      sent = 0;
      while (sent < 55) begin
        pat = pattern_t'($urandom_range(PAT_NOISE, PAT_CENTRE));
        run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
        for (int k = 0; k < run_len && sent < 55; k++) begin
          unique case (pat)
            PAT_CENTRE: begin
              ls = sample_above(cur_threshold);
              rs = sample_above(cur_threshold);
            end
            PAT_LEFT: begin
              ls = sample_above(cur_threshold);
              rs = sample_below(cur_threshold);
            end
            PAT_RIGHT: begin
              ls = sample_below(cur_threshold);
              rs = sample_above(cur_threshold);
            end
            PAT_LOST: begin
              ls = sample_below(cur_threshold);
              rs = sample_below(cur_threshold);
            end
            default: begin
              ls = $urandom_range(SAMPLE_MAX, 0);
              rs = $urandom_range(SAMPLE_MAX, 0);
            end
          endcase
          send_pair(ls, rs);
          sent++;
          if (round == 0 && sent == 27) hold_until_drained();
        end
      end
    end
  endtask

  initial begin
    int wait_cycles;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_threshold = 512;
    cur_kp = 20;
    cur_kd = 10;
    cur_speed = 100;
    line_err = ERR_CENTRE;
    err_at_change = ERR_CENTRE;
    prior_run = '0;
    this_run = '0;
    idle_pct = 0;
    stall_pct = 0;
    fail_count = 0;
    pairs_sent = 0;
    results_checked = 0;
    reg_writes = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_start_and_sensor_cases();
    test_register_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(88, 0);
    test_random_traffic(0, 88);
    test_random_traffic(21, 21);

    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_steer.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_steer.size() != 0) begin
      $error("%0d steering results never arrived", pending_steer.size());
      fail_count += pending_steer.size();
    end

    $display("Checked %0d steering results from %0d sensor pairs, %0d register writes.",
             results_checked, pairs_sent, reg_writes);
    $display("Covered zero-divisor start, lost line both ways, clipping, four idle mixes.");
    if (fail_count == 0) begin
      $display("line_follow_pd_steering_top_test: PASS");
    end else begin
      $display("line_follow_pd_steering_top_test: FAIL");
    end
    $finish;
  end

endmodule
